// File: rtl/bb3c_pkg.sv
package bb3c_pkg;

  // Line buffer depth and the column counter that indexes it
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int ROW_W       = 16;
  localparam int OUT_COL_W   = 10;
  localparam int FWIDTH_W    = 11;
  localparam int FHEIGHT_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

  // Register values after reset
  localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd64;
  localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd64;

  // Nine-sample sum and divide by 9 through a reciprocal:
  // floor(n * RECIP / 2^RECIP_SH) == floor(n / 9) for n < 2^21
  localparam int SUM_W    = 20;
  localparam int MAG_W    = 19;
  localparam int RECIP_W  = 19;
  localparam int RECIP_SH = 22;
  localparam logic [RECIP_W-1:0] RECIP = 19'd466034;
  localparam logic [MAG_W-1:0]   ROUND_BIAS = 19'd4;

endpackage

// File: rtl/bb3c_ram.sv
module bb3c_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/box_blur_3x3_clamped.sv
// 3x3 box filter with edge clamping over a height map streamed in raster order.
// Each result is the rounded mean of the nine samples around one pixel, where a
// neighbor outside the map counts as the center sample; results carry their
// row and column, mark the last result of each input transfer and flag the
// final pixel of the frame. The input at (r,c) yields (r-1,c-1), plus (r-1,W-1)
// at the end of a row, plus pixels of row r itself in the last row, so the
// whole map comes out one row and one column behind the input. A sample is
// taken every clock while each input causes at most one result and the output
// is not stalled; an input with more results holds the input side until the
// window has passed them all on, as the output port moves one result per cycle
// (two per item at row ends, up to four at the final pixel). The two previous
// rows sit in two line memories read at input transfer and written back when
// the sample enters the window. Writing frame_width or frame_height restarts
// the frame at row 0, column 0; write them only while the block is idle.
module box_blur_3x3_clamped (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bb3c_pkg::SAMPLE_W-1:0]  in_height_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bb3c_pkg::ROW_W-1:0]            out_row,
  output logic [bb3c_pkg::OUT_COL_W-1:0]        out_col,
  output logic signed [bb3c_pkg::SAMPLE_W-1:0]  out_blurred,
  output logic                                  out_last_of_run,
  output logic                                  out_frame_done,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bb3c_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bb3c_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import bb3c_pkg::*;

  // Configuration and frame geometry
  logic [FWIDTH_W-1:0]  frame_width_r;
  logic [FHEIGHT_W-1:0] frame_height_r;
  logic [COL_W-1:0]     w_m1;
  logic [ROW_W-1:0]     h_m1;
  logic                 cfg_fire;
  logic                 cfg_hit;

  // Position counters
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             in_fire;
  logic             c_last;
  logic             r_last;

  // Read stage: line memory data arrives here
  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_x_r;
  logic [COL_W-1:0]           s1_col_r;
  logic [ROW_W-1:0]           s1_row_r;
  logic                       s1_c_last_r;
  logic                       s1_r_last_r;
  logic                       s1_adv;
  logic [3:0]                 s1_mask;
  logic [SAMPLE_W-1:0]        top_rd;
  logic [SAMPLE_W-1:0]        mid_rd;

  // Window stage
  logic signed [SAMPLE_W-1:0] win_r [3][3];
  logic [3:0]                 pend_r;
  logic [ROW_W-1:0]           e_row_r;
  logic [COL_W-1:0]           e_col_r;
  logic                       e_r_ge2_r;
  logic                       e_c_ge2_r;
  logic [3:0]                 pick;
  logic [3:0]                 remaining;
  logic                       e_adv;
  logic                       win_free;
  logic [1:0]                 sel_ci;
  logic [1:0]                 sel_ck;
  logic                       sel_up;
  logic                       sel_down;
  logic                       sel_left;
  logic                       sel_right;
  logic [ROW_W-1:0]           sel_row;
  logic [COL_W-1:0]           sel_col;
  logic                       sel_done;
  logic signed [SUM_W-1:0]    win_sum;

  // Sum stage
  logic                    s_valid_r;
  logic signed [SUM_W-1:0] s_sum_r;
  logic [ROW_W-1:0]        s_row_r;
  logic [COL_W-1:0]        s_col_r;
  logic                    s_last_r;
  logic                    s_done_r;
  logic                    s_ready;
  logic [MAG_W-1:0]        s_mag;

  // Product stage
  logic                       p_valid_r;
  logic [MAG_W+RECIP_W-1:0]   p_prod_r;
  logic                       p_neg_r;
  logic [ROW_W-1:0]           p_row_r;
  logic [COL_W-1:0]           p_col_r;
  logic                       p_last_r;
  logic                       p_done_r;
  logic                       p_ready;
  logic [SAMPLE_W-1:0]        p_quot;

  // Output register
  logic out_valid_r;
  logic o_ready;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Only a write to a known register restarts the frame
  assign cfg_hit = cfg_fire &&
                   ((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FWIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the geometry into its legal range
  always_comb begin
    if (frame_width_r < FWIDTH_W'(2)) begin
      w_m1 = COL_W'(1);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      w_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(frame_width_r - FWIDTH_W'(1));
    end
    if (frame_height_r < FHEIGHT_W'(2)) begin
      h_m1 = ROW_W'(1);
    end else begin
      h_m1 = ROW_W'(frame_height_r - FHEIGHT_W'(1));
    end
  end

  // Handshake chain, from the output back to the input
  assign o_ready   = !out_valid_r || out_ready;
  assign p_ready   = !p_valid_r || o_ready;
  assign s_ready   = !s_valid_r || p_ready;
  assign pick      = pend_r & (~pend_r + 4'd1);
  assign e_adv     = (pend_r != 4'd0) && s_ready;
  assign remaining = e_adv ? (pend_r & ~pick) : pend_r;
  assign win_free  = (remaining == 4'd0);
  assign s1_adv    = s1_valid_r && win_free;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_valid && in_ready;

  assign c_last = (col_r == w_m1);
  assign r_last = (row_r == h_m1);

  // Advance the raster position; restart on a configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (c_last) begin
        col_r <= '0;
        row_r <= r_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // Line memories: read at input transfer, write back when the sample enters the window
  bb3c_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_x_r),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (mid_rd)
  );

  bb3c_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (top_rd)
  );

  // Hold the accepted sample while its line data is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r      <= in_height_sample;
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_c_last_r <= c_last;
      s1_r_last_r <= r_last;
    end
  end

  // Results this sample causes, in delivery order
  assign s1_mask[0] = (s1_row_r != '0) && (s1_col_r != '0);
  assign s1_mask[1] = (s1_row_r != '0) && s1_c_last_r;
  assign s1_mask[2] = s1_r_last_r && (s1_col_r != '0);
  assign s1_mask[3] = s1_r_last_r && s1_c_last_r;

  // Shift the window and load the pending results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      pend_r <= s1_mask;
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= top_rd;
      win_r[1][2] <= mid_rd;
      win_r[2][2] <= s1_x_r;
    end else begin
      pend_r <= remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      e_row_r   <= s1_row_r;
      e_col_r   <= s1_col_r;
      e_r_ge2_r <= (s1_row_r > ROW_W'(1));
      e_c_ge2_r <= (s1_col_r > COL_W'(1));
    end
  end

  // Center cell, clamping flags and coordinates of the picked result
  always_comb begin
    sel_ci    = 2'd1;
    sel_ck    = 2'd1;
    sel_up    = e_r_ge2_r;
    sel_down  = 1'b1;
    sel_left  = e_c_ge2_r;
    sel_right = 1'b1;
    sel_row   = e_row_r - ROW_W'(1);
    sel_col   = e_col_r - COL_W'(1);
    sel_done  = 1'b0;
    case (pick)
      4'b0010: begin
        sel_ck    = 2'd2;
        sel_left  = 1'b1;
        sel_right = 1'b0;
        sel_col   = e_col_r;
      end
      4'b0100: begin
        sel_ci   = 2'd2;
        sel_up   = 1'b1;
        sel_down = 1'b0;
        sel_row  = e_row_r;
      end
      4'b1000: begin
        sel_ci    = 2'd2;
        sel_ck    = 2'd2;
        sel_up    = 1'b1;
        sel_down  = 1'b0;
        sel_left  = 1'b1;
        sel_right = 1'b0;
        sel_row   = e_row_r;
        sel_col   = e_col_r;
        sel_done  = 1'b1;
      end
      default: ;
    endcase
  end

  // Sum the neighborhood, replacing cut-off neighbors by the center
  always_comb begin
    logic [2:0]                 ri;
    logic [2:0]                 cj;
    logic                       keep;
    logic signed [SAMPLE_W-1:0] term;
    logic signed [SAMPLE_W-1:0] centre;
    centre  = win_r[sel_ci][sel_ck];
    win_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri = 3'(i) + {2'b00, sel_ci[1]};
        cj = 3'(j) + {2'b00, sel_ck[1]};
        if (ri > 3'd2) ri = 3'd2;
        if (cj > 3'd2) cj = 3'd2;
        keep = 1'b1;
        if (i == 0 && !sel_up) keep = 1'b0;
        if (i == 2 && !sel_down) keep = 1'b0;
        if (j == 0 && !sel_left) keep = 1'b0;
        if (j == 2 && !sel_right) keep = 1'b0;
        term    = keep ? win_r[ri[1:0]][cj[1:0]] : centre;
        win_sum = win_sum + {{(SUM_W-SAMPLE_W){term[SAMPLE_W-1]}}, term};
      end
    end
  end

  // Sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (s_ready) begin
      s_valid_r <= (pend_r != 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv) begin
      s_sum_r  <= win_sum;
      s_row_r  <= sel_row;
      s_col_r  <= sel_col;
      s_last_r <= ((pend_r & ~pick) == 4'd0);
      s_done_r <= sel_done;
    end
  end

  // Magnitude plus half the divisor, then the reciprocal product
  assign s_mag = s_sum_r[SUM_W-1] ? MAG_W'(-s_sum_r) + ROUND_BIAS
                                  : MAG_W'(s_sum_r) + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_ready) begin
      p_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid_r && p_ready) begin
      p_prod_r <= s_mag * RECIP;
      p_neg_r  <= s_sum_r[SUM_W-1];
      p_row_r  <= s_row_r;
      p_col_r  <= s_col_r;
      p_last_r <= s_last_r;
      p_done_r <= s_done_r;
    end
  end

  assign p_quot = p_prod_r[RECIP_SH +: SAMPLE_W];

  // Output register: restore the sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid_r && o_ready) begin
      out_blurred     <= p_neg_r ? -p_quot : p_quot;
      out_row         <= p_row_r;
      out_col         <= OUT_COL_W'(p_col_r);
      out_last_of_run <= p_last_r;
      out_frame_done  <= p_done_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // Column position never leaves the row
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_m1)
    else $error("column counter beyond frame width");

  // The final pixel of a frame returns the position to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && c_last && r_last |=> (row_r == '0) && (col_r == '0))
    else $error("position did not wrap after final pixel");

  // Line write-back never hits the entry being read in the same cycle
  a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && in_fire |-> s1_col_r != col_r)
    else $error("line memory write and read at the same column");

  // The frame-done result always closes its run
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_done |-> out_last_of_run)
    else $error("frame done without last of run");
`endif

endmodule

// File: tb/box_blur_3x3_clamped_tb.sv
`timescale 1ns / 100ps

module box_blur_3x3_clamped_tb;
  import bb3c_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 10;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_CYCLES = 1500000;
  localparam int RANDOM_ITEMS   = 50;

  // No register lives at this index; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hFF;

  typedef enum logic [0:0] {
    STEP_CFG,
    STEP_PIX
  } step_kind_e;

  // One row of the directed plan: a register write or a run of equal samples
  typedef struct packed {
    step_kind_e                 kind;
    logic [CFG_IDX_W-1:0]       index;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SAMPLE_W-1:0] sample;
    logic [15:0]                reps;
    logic                       fixed_mean;
    logic signed [SAMPLE_W-1:0] mean_value;
  } plan_row_t;

  typedef struct packed {
    logic [ROW_W-1:0]           row;
    logic [OUT_COL_W-1:0]       col;
    logic signed [SAMPLE_W-1:0] blurred;
    logic                       last_of_run;
    logic                       frame_done;
  } pixel_t;

  // A constant map blurs to itself, so those rows carry their mean directly
  localparam plan_row_t PLAN [27] = '{
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh1234, 16'd67, 1'b1, 16'sh1234},
    '{STEP_CFG, CFG_FRAME_WIDTH,  16'd2,     16'sh0000, 16'd0,  1'b0, 16'sh0000},
    '{STEP_CFG, CFG_FRAME_HEIGHT, 16'd2,     16'sh0000, 16'd0,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh7FFF, 16'd4,  1'b1, 16'sh7FFF},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh8000, 16'd4,  1'b1, 16'sh8000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh7FFF, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh8000, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh0001, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'shFFFF, 16'd1,  1'b0, 16'sh0000},
    '{STEP_CFG, CFG_FRAME_WIDTH,  16'd0,     16'sh0000, 16'd0,  1'b0, 16'sh0000},
    '{STEP_CFG, CFG_FRAME_HEIGHT, 16'd1,     16'sh0000, 16'd0,  1'b0, 16'sh0000},
    '{STEP_CFG, CFG_UNUSED_IDX,   16'hFFFF,  16'sh0000, 16'd0,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh0000, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh5555, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'shAAAA, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh0007, 16'd1,  1'b0, 16'sh0000},
    '{STEP_CFG, CFG_FRAME_WIDTH,  16'd3,     16'sh0000, 16'd0,  1'b0, 16'sh0000},
    '{STEP_CFG, CFG_FRAME_HEIGHT, 16'd3,     16'sh0000, 16'd0,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'shFFFC, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'shFFFB, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh0004, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh0005, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh0064, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'shFF9C, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh7FFF, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh8000, 16'd1,  1'b0, 16'sh0000},
    '{STEP_PIX, CFG_FRAME_WIDTH,  16'd0,     16'sh0000, 16'd1,  1'b0, 16'sh0000}
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_height_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [ROW_W-1:0]           out_row;
  logic [OUT_COL_W-1:0]       out_col;
  logic signed [SAMPLE_W-1:0] out_blurred;
  logic                       out_last_of_run;
  logic                       out_frame_done;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Blur predictor state: line stores, window, position and registers
  logic signed [SAMPLE_W-1:0] above_row [MAX_WIDTH];
  logic signed [SAMPLE_W-1:0] two_above_row [MAX_WIDTH];
  logic signed [SAMPLE_W-1:0] win [3][3];
  int                         row_pos;
  int                         col_pos;
  logic [FWIDTH_W-1:0]        width_reg;
  logic [FHEIGHT_W-1:0]       height_reg;

  pixel_t expected_pixels [$];
  int     mismatch_count = 0;
  bit     in_burst = 1'b0;
  bit     out_burst = 1'b0;
  int     out_stall_left = 0;

  box_blur_3x3_clamped dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 24);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 39))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int active_width();
    int w;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int active_height();
    return (height_reg < 2) ? 2 : int'(height_reg);
  endfunction

  // Mean of the 3x3 cells around window cell (ci,ck); cells off the map take the center
  function automatic logic signed [SAMPLE_W-1:0] clamped_mean(int ci, int ck, bit up,
                                                             bit down, bit left, bit right);
    int  sum;
    int  mean;
    bit  in_map;
    sum = 0;
    for (int di = -1; di <= 1; di++) begin
      for (int dk = -1; dk <= 1; dk++) begin
        in_map = !((di < 0 && !up) || (di > 0 && !down) ||
                   (dk < 0 && !left) || (dk > 0 && !right));
        if (in_map && ci + di >= 0 && ci + di <= 2 && ck + dk >= 0 && ck + dk <= 2) begin
          sum += win[ci + di][ck + dk];
        end else begin
          sum += win[ci][ck];
        end
      end
    end
    // Round half away from zero
    mean = (sum >= 0) ? (sum + 4) / 9 : -((-sum + 4) / 9);
    return SAMPLE_W'(mean);
  endfunction

  function automatic void queue_pixel(int r, int c, int ci, int ck, int w, int h);
    pixel_t p;
    p.row         = ROW_W'(r);
    p.col         = OUT_COL_W'(c);
    p.blurred     = clamped_mean(ci, ck, r > 0, r < h - 1, c > 0, c < w - 1);
    p.last_of_run = 1'b0;
    p.frame_done  = (r == h - 1 && c == w - 1);
    expected_pixels.push_back(p);
  endfunction

  // Advance the predictor by one sample and queue the pixels it completes
  task automatic predict_blur(input logic signed [SAMPLE_W-1:0] s, output int made);
    int w, h, r, c, first;
    logic signed [SAMPLE_W-1:0] top, mid;
    w = active_width();
    h = active_height();
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    top = two_above_row[c];
    mid = above_row[c];
    two_above_row[c] = mid;
    above_row[c] = s;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = s;

    first = expected_pixels.size();
    if (r >= 1 && c >= 1) queue_pixel(r - 1, c - 1, 1, 1, w, h);
    if (r >= 1 && c == w - 1) queue_pixel(r - 1, c, 1, 2, w, h);
    if (r == h - 1 && c >= 1) queue_pixel(r, c - 1, 2, 1, w, h);
    if (r == h - 1 && c == w - 1) queue_pixel(r, c, 2, 2, w, h);
    made = expected_pixels.size() - first;
    if (made > 0) expected_pixels[$].last_of_run = 1'b1;

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Offer one sample, hold it until the transfer, then maybe drop valid for a gap
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic fixed_mean,
                             input logic signed [SAMPLE_W-1:0] mean_value);
    int made;
    in_valid         <= 1'b1;
    in_height_sample <= s;
    do @(posedge clk); while (!in_ready);
    predict_blur(s, made);
    if (fixed_mean) begin
      for (int k = 1; k <= made; k++) begin
        expected_pixels[expected_pixels.size() - k].blurred = mean_value;
      end
    end
    if (!in_burst && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    // Track the register and restart the frame, as the block does
    case (idx)
      CFG_FRAME_WIDTH: begin
        width_reg = value[FWIDTH_W-1:0];
        row_pos   = 0;
        col_pos   = 0;
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = value[FHEIGHT_W-1:0];
        row_pos    = 0;
        col_pos    = 0;
      end
      default: ;
    endcase
  endtask

  // Hold off until every pending pixel is out and the pipeline has emptied
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output side: random stalls of mixed length, no new one begun while out_burst is set
  always @(posedge clk) begin
    if (out_stall_left > 0) begin
      out_ready      <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (!out_burst && $urandom_range(0, 3) == 0) begin
      out_ready      <= 1'b0;
      out_stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest pending pixel
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_row, out_col, out_blurred, out_last_of_run, out_frame_done};
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected pixel row %0d col %0d blurred %0d last %0b done %0b",
                 $time, got.row, got.col, got.blurred, got.last_of_run, got.frame_done);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: expected row %0d col %0d blurred %0d last %0b done %0b",
                   $time, want.row, want.col, want.blurred, want.last_of_run,
                   want.frame_done);
          $display("%0t:   actual row %0d col %0d blurred %0d last %0b done %0b",
                   $time, got.row, got.col, got.blurred, got.last_of_run, got.frame_done);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int random_items;
    int w_set, h_set, frame_len, n;

    for (int i = 0; i < MAX_WIDTH; i++) begin
      above_row[i]     = '0;
      two_above_row[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) win[i][k] = '0;
    end
    row_pos    = 0;
    col_pos    = 0;
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    random_items = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan, starting at the reset register values
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == STEP_CFG) begin
        wait_drained();
        write_cfg(PLAN[i].index, PLAN[i].data);
      end else begin
        repeat (PLAN[i].reps) send_sample(PLAN[i].sample, PLAN[i].fixed_mean,
                                          PLAN[i].mean_value);
      end
    end

    // Tallest frame: run a few rows, then restart through a register write
    wait_drained();
    write_cfg(CFG_FRAME_WIDTH, 16'd2);
    write_cfg(CFG_FRAME_HEIGHT, 16'hFFFF);
    repeat (12) send_sample(random_sample(), 1'b0, '0);

    // Random phases: mostly whole frames of small size, some cut short
    while (random_items < RANDOM_ITEMS) begin
      wait_drained();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2: w_set = $urandom_range(0, 1);
        3, 4, 5: w_set = $urandom_range(7, 12);
        default: w_set = $urandom_range(2, 6);
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: h_set = $urandom_range(0, 1);
        3, 4, 5: h_set = $urandom_range(6, 10);
        default: h_set = $urandom_range(2, 5);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_cfg(CFG_FRAME_WIDTH, CFG_DATA_W'(w_set));
        write_cfg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h_set));
      end else begin
        write_cfg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h_set));
        write_cfg(CFG_FRAME_WIDTH, CFG_DATA_W'(w_set));
      end
      if ($urandom_range(0, 4) == 0) begin
        write_cfg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
      end
      frame_len = active_width() * active_height();
      if ($urandom_range(0, 9) < 7) begin
        n = (frame_len > 60) ? frame_len : frame_len * $urandom_range(1, 2);
      end else begin
        n = $urandom_range(1, frame_len);
      end
      // Stay within the item budget; the last frame may be cut short
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      repeat (n) send_sample(random_sample(), 1'b0, '0);
      random_items += n;
    end

    // Drain, then let the pipeline settle before the verdict
    in_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && expected_pixels.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      mismatch_count += expected_pixels.size();
      $display("%0t: %0d expected pixels never arrived, oldest row %0d col %0d",
               $time, expected_pixels.size(), expected_pixels[0].row,
               expected_pixels[0].col);
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
